>>> rtl/crfpw_pkg.sv
// Package for the clipped rectangle fill pixel writer.
// Holds register indexes, sequencer states, field widths and pixel packing.
// No dependencies.
package crfpw_pkg;

  localparam int unsigned DEF_MAX_SPAN   = 8;
  localparam int unsigned DEF_ADDR_WIDTH = 32;

  localparam int unsigned COORD_W  = 16;
  localparam int unsigned SPAN_W   = 4;
  localparam int unsigned COLOR_W  = 32;
  localparam int unsigned SCREEN_W = 14;
  localparam int unsigned PITCH_W  = 16;
  localparam int unsigned BPP_W    = 6;
  localparam int unsigned BASE_W   = 32;
  localparam int unsigned BYTES_W  = 3;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 32;

  localparam int unsigned IN_TDATA_W  = 72;
  localparam int unsigned OUT_TDATA_W = 72;

  localparam logic [BPP_W-1:0] BPP_16 = 6'd16;
  localparam logic [BPP_W-1:0] BPP_24 = 6'd24;
  localparam logic [BPP_W-1:0] BPP_32 = 6'd32;

  localparam logic [COLOR_W-1:0] MASK_RED   = 32'h00F8_0000;
  localparam logic [COLOR_W-1:0] MASK_GREEN = 32'h0000_FC00;
  localparam logic [COLOR_W-1:0] MASK_BLUE  = 32'h0000_00F8;
  localparam logic [COLOR_W-1:0] MASK_RGB   = 32'h00FF_FFFF;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SCREEN_WIDTH  = 3'd0,
    REG_SCREEN_HEIGHT = 3'd1,
    REG_ROW_PITCH     = 3'd2,
    REG_BITS_PER_PIX  = 3'd3,
    REG_BASE_ADDRESS  = 3'd4
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_ADD_Y,
    ST_ADD_X,
    ST_WALK
  } fill_state_t;

  function automatic logic [COLOR_W-1:0] pixel_word(input logic [COLOR_W-1:0] color,
                                                    input logic [BPP_W-1:0] bpp);
    logic [COLOR_W-1:0] rgb565;
    rgb565 = ((color & MASK_RED) >> 8) | ((color & MASK_GREEN) >> 5) |
             ((color & MASK_BLUE) >> 3);
    if (bpp == BPP_32) begin
      pixel_word = color;
    end else if (bpp == BPP_24) begin
      pixel_word = color & MASK_RGB;
    end else begin
      pixel_word = rgb565;
    end
  endfunction

endpackage

>>> rtl/clipped_rect_fill_pixel_writer_core.sv
// Clipped rectangle fill pixel writer, top level.
// Depends on crfpw_pkg for register indexes, states and pixel packing.
//
// Takes one rectangle command at a time and emits one write word per on-screen
// pixel, columns in the outer loop and rows in the inner loop; the last word of a
// command carries tlast. A command with a supported depth, a nonzero base and a
// nonempty span goes through setup after its accept (row offset multiply,
// then two passes of the shared address adder) and then steps through each pixel
// of the width by height span, up to MAX_SPAN*MAX_SPAN pixels, even where every
// pixel is off screen, waiting at an on-screen pixel while the output side stalls.
// The single address adder steps by the row pitch down a column and by the pixel
// size across columns. s_axis_tready is high only between commands and low during
// reset; any other command is accepted and yields no write words. Configuration
// writes are taken whenever cfg_we is high outside reset.
module clipped_rect_fill_pixel_writer_core
  import crfpw_pkg::*;
#(
  parameter int unsigned MAX_SPAN   = DEF_MAX_SPAN,
  parameter int unsigned ADDR_WIDTH = DEF_ADDR_WIDTH
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // origin_x[15:0], origin_y[31:16], rect_width[35:32], rect_height[39:36],
  // fill_color[71:40]
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // write_address[31:0], write_data[63:32], write_bytes[66:64], zero[71:67]
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,
  output logic                   m_axis_tlast
);

  localparam int unsigned AW = ADDR_WIDTH;
  localparam logic [SPAN_W-1:0] SPAN_MAX = SPAN_W'(MAX_SPAN);

  logic [SCREEN_W-1:0] screen_width;
  logic [SCREEN_W-1:0] screen_height;
  logic [PITCH_W-1:0]  row_pitch;
  logic [BPP_W-1:0]    bits_per_pixel;
  logic [BASE_W-1:0]   base_address;

  fill_state_t state, state_next;

  logic signed [COORD_W-1:0] ox;
  logic signed [COORD_W-1:0] oy;
  logic [SPAN_W-1:0]         span_w;
  logic [SPAN_W-1:0]         span_h;
  logic [COLOR_W-1:0]        pix_data;
  logic [BYTES_W-1:0]        pix_bytes;
  logic signed [32:0]        prod;
  logic signed [18:0]        ox_off;
  logic [AW-1:0]             col_addr;
  logic [AW-1:0]             pix_addr;
  logic [SPAN_W-1:0]         col;
  logic [SPAN_W-1:0]         row;
  logic signed [16:0]        px;
  logic signed [16:0]        py;

  logic [31:0]               out_addr;
  logic [COLOR_W-1:0]        out_data;
  logic [BYTES_W-1:0]        out_bytes;
  logic                      out_last;
  logic                      out_valid;

  logic signed [COORD_W-1:0] in_ox;
  logic signed [COORD_W-1:0] in_oy;
  logic [SPAN_W-1:0]         in_w;
  logic [SPAN_W-1:0]         in_h;
  logic [COLOR_W-1:0]        in_color;
  logic [SPAN_W-1:0]         in_w_sat;
  logic [SPAN_W-1:0]         in_h_sat;
  logic                      depth_ok;
  logic                      fill_ok;
  logic                      in_fire;

  logic [AW-1:0]             op_a;
  logic [AW-1:0]             op_b;
  logic [AW-1:0]             sum;
  logic signed [16:0]        px_inc;
  logic signed [16:0]        py_inc;
  logic                      col_end;
  logic                      row_end;
  logic                      pix_ok;
  logic                      pix_last;
  logic                      out_free;
  logic                      step;
  logic                      load_out;

  always_ff @(posedge clk) begin
    if (rst) begin
      screen_width   <= '0;
      screen_height  <= '0;
      row_pitch      <= '0;
      bits_per_pixel <= '0;
      base_address   <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SCREEN_WIDTH:  screen_width   <= cfg_data[SCREEN_W-1:0];
        REG_SCREEN_HEIGHT: screen_height  <= cfg_data[SCREEN_W-1:0];
        REG_ROW_PITCH:     row_pitch      <= cfg_data[PITCH_W-1:0];
        REG_BITS_PER_PIX:  bits_per_pixel <= cfg_data[BPP_W-1:0];
        REG_BASE_ADDRESS:  base_address   <= cfg_data[BASE_W-1:0];
        default: ;
      endcase
    end
  end

  assign in_ox    = s_axis_tdata[15:0];
  assign in_oy    = s_axis_tdata[31:16];
  assign in_w     = s_axis_tdata[35:32];
  assign in_h     = s_axis_tdata[39:36];
  assign in_color = s_axis_tdata[71:40];
  assign in_w_sat = (in_w > SPAN_MAX) ? SPAN_MAX : in_w;
  assign in_h_sat = (in_h > SPAN_MAX) ? SPAN_MAX : in_h;
  assign depth_ok = (bits_per_pixel == BPP_16) || (bits_per_pixel == BPP_24) ||
                    (bits_per_pixel == BPP_32);
  assign fill_ok  = depth_ok && (base_address != '0) && (in_w_sat != '0) &&
                    (in_h_sat != '0);

  assign s_axis_tready = (state == ST_IDLE) && !rst;
  assign in_fire       = s_axis_tvalid && s_axis_tready;

  assign px_inc  = px + 17'sd1;
  assign py_inc  = py + 17'sd1;
  assign col_end = (col == span_w - 4'd1);
  assign row_end = (row == span_h - 4'd1);
  assign pix_ok  = (px >= 17'sd0) && (px < $signed({3'b000, screen_width})) &&
                   (py >= 17'sd0) && (py < $signed({3'b000, screen_height}));
  assign pix_last = (col_end || (px_inc >= $signed({3'b000, screen_width}))) &&
                    (row_end || (py_inc >= $signed({3'b000, screen_height})));

  assign out_free = !out_valid || m_axis_tready;

  // shared address adder
  always_comb begin
    op_a = col_addr;
    op_b = '0;
    unique case (state)
      ST_ADD_Y: op_b = AW'(prod);
      ST_ADD_X: op_b = AW'(ox_off);
      ST_WALK: begin
        if (row_end) begin
          op_b = AW'(pix_bytes);
        end else begin
          op_a = pix_addr;
          op_b = AW'(row_pitch);
        end
      end
      default: ;
    endcase
  end
  assign sum = op_a + op_b;

  always_comb begin
    state_next = state;
    step       = 1'b0;
    load_out   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (in_fire && fill_ok) state_next = ST_MUL;
      end
      ST_MUL:   state_next = ST_ADD_Y;
      ST_ADD_Y: state_next = ST_ADD_X;
      ST_ADD_X: state_next = ST_WALK;
      ST_WALK: begin
        step     = !pix_ok || out_free;
        load_out = pix_ok && out_free;
        if (step && row_end && col_end) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      ox        <= in_ox;
      oy        <= in_oy;
      span_w    <= in_w_sat;
      span_h    <= in_h_sat;
      pix_data  <= pixel_word(in_color, bits_per_pixel);
      pix_bytes <= bits_per_pixel[5:3];
      col_addr  <= AW'(base_address);
    end
    if (state == ST_MUL) begin
      prod <= 33'(oy) * $signed({17'd0, row_pitch});
      unique case (pix_bytes)
        3'd2:    ox_off <= 19'(ox) <<< 1;
        3'd3:    ox_off <= (19'(ox) <<< 1) + 19'(ox);
        default: ox_off <= 19'(ox) <<< 2;
      endcase
      col <= '0;
      row <= '0;
      px  <= 17'(ox);
      py  <= 17'(oy);
    end
    if (state == ST_ADD_Y) begin
      col_addr <= sum;
    end
    if (state == ST_ADD_X) begin
      col_addr <= sum;
      pix_addr <= sum;
    end
    if (step) begin
      if (row_end) begin
        col      <= col + 4'd1;
        row      <= '0;
        px       <= px_inc;
        py       <= 17'(oy);
        col_addr <= sum;
        pix_addr <= sum;
      end else begin
        row      <= row + 4'd1;
        py       <= py_inc;
        pix_addr <= sum;
      end
    end
    if (load_out) begin
      out_addr  <= 32'(pix_addr);
      out_data  <= pix_data;
      out_bytes <= pix_bytes;
      out_last  <= pix_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {5'b00000, out_bytes, out_data, out_addr};
  assign m_axis_tlast  = out_last;

endmodule
